>>> design/sef_pkg.sv
// Shared types and constants for the scaler event record formatter.
`default_nettype none

package sef_pkg;

  // Input item kinds carried on in_tuser
  typedef enum logic [1:0] {
    FUNC_START   = 2'd0,
    FUNC_HEADER  = 2'd1,
    FUNC_CHANNEL = 2'd2
  } func_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DATA_ID        = 3'd0,
    REG_CRATE_NUMBER   = 3'd1,
    REG_SLOT_NUMBER    = 3'd2,
    REG_ENABLED_MASK   = 3'd3,
    REG_ENABLED_COUNT  = 3'd4,
    REG_COUNT_OFFSET   = 3'd5,
    REG_CLEAR_ON_START = 3'd6
  } reg_idx_t;

  localparam int MAX_CHANNELS_DEF = 32;

  // Words in the record head, and the largest burst one beat can cause
  localparam int HEAD_WORDS = 5;
  localparam int BUF_DEPTH  = 6;

  localparam logic [31:0] BAD_WORD = 32'hffff_ffff;

endpackage

`default_nettype wire

>>> design/scaler_event_record_formatter.sv
// Scaler event record formatter: builds record words from header and channel beats.
// The first result word is registered: it appears the cycle after the input beat is accepted.
// Throughput: one input beat per cycle while out_tready is high; a channel-0 beat loads
// a six-word burst into the output buffer; input stalls until its last word leaves.
// A header beat with no channels enabled loads a five-word burst the same way.
// Reset (rst_n low, synchronous): config regs zero, wrap tracking cleared, buffer empty.
`default_nettype none

module scaler_event_record_formatter
  import sef_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] word_in
  input  wire logic [1:0]  in_tuser,   // [1:0] func

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] word_out
  output logic             out_tlast,  // last_word
  output logic             out_tuser,  // [0] bad_count

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_data
);

  localparam logic [5:0] MAX_N   = 6'(MAX_CHANNELS);
  localparam int         CNT_W   = $clog2(BUF_DEPTH + 1);

  // configuration
  logic [31:0] data_id_r;
  logic [3:0]  crate_r;
  logic [4:0]  slot_r;
  logic [31:0] mask_r;
  logic [5:0]  en_count_r;
  logic [31:0] offset_r;
  logic        clear_on_start_r;

  // tracking state
  logic [31:0] last_count_r, last_count_nxt;
  logic [31:0] wrap_count_r, wrap_count_nxt;
  logic [31:0] held_header_r, held_header_nxt;
  logic [5:0]  chan_idx_r, chan_idx_nxt;

  // output burst buffer
  logic [31:0]      buf_word_r [BUF_DEPTH];
  logic [31:0]      buf_word_nxt [BUF_DEPTH];
  logic [CNT_W-1:0] buf_cnt_r, buf_cnt_nxt;
  logic             buf_last_r, buf_last_nxt;
  logic             buf_bad_r, buf_bad_nxt;

  logic        in_acc, out_acc;
  logic [5:0]  n_act;
  logic [31:0] id_word, loc_word;
  logic [32:0] lo_sum;
  logic [31:0] hi_sum;
  logic        wrap_inc, rec_last;
  logic [31:0] ch0_high, ch0_val;
  logic        ch0_bad;
  func_t       func;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = (buf_cnt_r != '0);
  assign in_tready  = (buf_cnt_r == '0) ||
                      ((buf_cnt_r == CNT_W'(1)) && out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = buf_word_r[0];
  assign out_tlast  = buf_last_r && (buf_cnt_r == CNT_W'(1));
  assign out_tuser  = buf_bad_r;
  assign func       = func_t'(in_tuser);

  always_comb begin
    n_act    = (en_count_r > MAX_N) ? MAX_N : en_count_r;
    id_word  = data_id_r | (32'(n_act) + 32'(HEAD_WORDS));
    loc_word = {7'd0, crate_r, slot_r, 16'd0};
    rec_last = ((chan_idx_r + 6'd1) == n_act);

    // extend channel 0: both halves of the 64-bit sum in parallel
    wrap_inc = (in_tdata < last_count_r);
    lo_sum   = {1'b0, in_tdata} + {1'b0, offset_r};
    hi_sum   = wrap_count_r + {32{offset_r[31]}} + {31'd0, lo_sum[32]} + {31'd0, wrap_inc};

    ch0_high = 32'd0;
    ch0_val  = in_tdata;
    ch0_bad  = 1'b0;
    if (mask_r[0]) begin
      if (in_tdata != 32'd0) begin
        ch0_high = hi_sum;
        ch0_val  = lo_sum[31:0];
      end else begin
        ch0_high = BAD_WORD;
        ch0_val  = BAD_WORD;
        ch0_bad  = 1'b1;
      end
    end
  end

  always_comb begin
    last_count_nxt  = last_count_r;
    wrap_count_nxt  = wrap_count_r;
    held_header_nxt = held_header_r;
    chan_idx_nxt    = chan_idx_r;
    buf_cnt_nxt     = buf_cnt_r;
    buf_last_nxt    = buf_last_r;
    buf_bad_nxt     = buf_bad_r;

    // drain: shift the burst down one word per beat taken
    for (int i = 0; i < BUF_DEPTH; i++) begin
      buf_word_nxt[i] = buf_word_r[i];
    end
    if (out_acc) begin
      for (int i = 0; i < BUF_DEPTH - 1; i++) begin
        buf_word_nxt[i] = buf_word_r[i+1];
      end
      buf_cnt_nxt = buf_cnt_r - CNT_W'(1);
    end

    if (in_acc) begin
      unique case (func)
        FUNC_START: begin
          if (clear_on_start_r) begin
            last_count_nxt = 32'd0;
            wrap_count_nxt = 32'd0;
          end
        end
        FUNC_HEADER: begin
          held_header_nxt = in_tdata;
          chan_idx_nxt    = 6'd0;
          if (n_act == 6'd0) begin
            buf_word_nxt[0] = id_word;
            buf_word_nxt[1] = loc_word;
            buf_word_nxt[2] = 32'd0;
            buf_word_nxt[3] = mask_r;
            buf_word_nxt[4] = in_tdata;
            buf_cnt_nxt     = CNT_W'(HEAD_WORDS);
            buf_last_nxt    = 1'b1;
            buf_bad_nxt     = 1'b0;
          end
        end
        FUNC_CHANNEL: begin
          if (chan_idx_r < n_act) begin
            chan_idx_nxt = chan_idx_r + 6'd1;
            buf_last_nxt = rec_last;
            if (chan_idx_r == 6'd0) begin
              if (mask_r[0] && (in_tdata != 32'd0)) begin
                last_count_nxt = in_tdata;
                wrap_count_nxt = wrap_count_r + {31'd0, wrap_inc};
              end
              buf_word_nxt[0] = id_word;
              buf_word_nxt[1] = loc_word;
              buf_word_nxt[2] = ch0_high;
              buf_word_nxt[3] = mask_r;
              buf_word_nxt[4] = held_header_r;
              buf_word_nxt[5] = ch0_val;
              buf_cnt_nxt     = CNT_W'(BUF_DEPTH);
              buf_bad_nxt     = ch0_bad;
            end else begin
              buf_word_nxt[0] = in_tdata;
              buf_cnt_nxt     = CNT_W'(1);
              buf_bad_nxt     = 1'b0;
            end
          end
        end
        default: begin
          // unused code: drop the beat
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_id_r        <= 32'd0;
      crate_r          <= 4'd0;
      slot_r           <= 5'd0;
      mask_r           <= 32'd0;
      en_count_r       <= 6'd0;
      offset_r         <= 32'd0;
      clear_on_start_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_DATA_ID:        data_id_r        <= cfg_data;
        REG_CRATE_NUMBER:   crate_r          <= cfg_data[3:0];
        REG_SLOT_NUMBER:    slot_r           <= cfg_data[4:0];
        REG_ENABLED_MASK:   mask_r           <= cfg_data;
        REG_ENABLED_COUNT:  en_count_r       <= cfg_data[5:0];
        REG_COUNT_OFFSET:   offset_r         <= cfg_data;
        REG_CLEAR_ON_START: clear_on_start_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= 32'd0;
      wrap_count_r <= 32'd0;
      chan_idx_r   <= 6'd0;
      buf_cnt_r    <= '0;
      buf_last_r   <= 1'b0;
      buf_bad_r    <= 1'b0;
    end else begin
      last_count_r <= last_count_nxt;
      wrap_count_r <= wrap_count_nxt;
      chan_idx_r   <= chan_idx_nxt;
      buf_cnt_r    <= buf_cnt_nxt;
      buf_last_r   <= buf_last_nxt;
      buf_bad_r    <= buf_bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_header_r <= held_header_nxt;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      buf_word_r[i] <= buf_word_nxt[i];
    end
  end

  // a beat is taken only when the buffer is empty or its final word leaves now
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ((buf_cnt_r == '0) || ((buf_cnt_r == CNT_W'(1)) && out_acc)))
    else $error("input beat accepted over a pending burst");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    buf_cnt_r <= CNT_W'(BUF_DEPTH))
    else $error("burst count out of range");

  a_hdr_resets_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == FUNC_HEADER)) |=> (chan_idx_r == 6'd0))
    else $error("header beat did not restart the channel index");

  a_burst_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && (buf_cnt_r > CNT_W'(1))) |=> (buf_cnt_r == $past(buf_cnt_r) - CNT_W'(1)))
    else $error("burst did not advance by one word");

endmodule

`default_nettype wire

>>> verif/tb_scaler_event_record_formatter.sv
// Testbench for the scaler event record formatter: directed and random beats, scoreboard check.
`default_nettype none

module tb_scaler_event_record_formatter;
  import sef_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_CH      = MAX_CHANNELS_DEF;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        bad;
  } rec_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] word_in
  logic [1:0]  in_tuser = '0;   // [1:0] func

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] word_out
  logic        out_tlast;       // last_word
  logic        out_tuser;       // [0] bad_count

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  scaler_event_record_formatter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow registers and record state of the formatter
  logic [31:0] rec_id;
  logic [3:0]  rec_crate;
  logic [4:0]  rec_slot;
  logic [31:0] rec_mask;
  logic [5:0]  rec_count;
  logic [31:0] rec_offset;
  logic        rec_clear;
  logic [31:0] last_cnt;
  logic [31:0] wrap_cnt;
  logic [31:0] hdr_word;
  logic [5:0]  chan_pos;

  rec_word_t   pending_words[$];
  int          mismatches = 0;

  // Stimulus-side bookkeeping
  int          gen_n = 0;
  logic [31:0] gen_last = '0;
  bit          gaps_on = 1'b1;
  int          burst_left = 0;

  function automatic void push_word(logic [31:0] word, logic last, logic bad);
    rec_word_t w;
    w.word = word;
    w.last = last;
    w.bad  = bad;
    pending_words.push_back(w);
  endfunction

  function automatic void push_head(logic [31:0] high, logic [5:0] n, logic bad);
    push_word(rec_id | (32'(HEAD_WORDS) + 32'(n)), 1'b0, bad);
    push_word({7'd0, rec_crate, rec_slot, 16'd0}, 1'b0, bad);
    push_word(high, 1'b0, bad);
    push_word(rec_mask, 1'b0, bad);
    push_word(hdr_word, n == 6'd0, bad);
  endfunction

  function automatic void format_beat(logic [1:0] func, logic [31:0] w);
    logic [5:0]  n;
    logic [63:0] full;
    logic [31:0] high;
    logic [31:0] val;
    logic        bad;
    logic        last;
    n = (rec_count > 6'(MAX_CH)) ? 6'(MAX_CH) : rec_count;
    case (func)
      FUNC_START: begin
        if (rec_clear) begin
          last_cnt = '0;
          wrap_cnt = '0;
        end
      end
      FUNC_HEADER: begin
        hdr_word = w;
        chan_pos = '0;
        if (n == 6'd0) push_head(32'd0, n, 1'b0);
      end
      FUNC_CHANNEL: begin
        if (chan_pos < n) begin
          last = (chan_pos + 6'd1 == n);
          if (chan_pos == 6'd0) begin
            high = '0;
            val  = w;
            bad  = 1'b0;
            if (rec_mask[0]) begin
              if (w != 32'd0) begin
                if (w < last_cnt) wrap_cnt = wrap_cnt + 32'd1;
                full = {wrap_cnt, w} + {{32{rec_offset[31]}}, rec_offset};
                last_cnt = w;
                high = full[63:32];
                val  = full[31:0];
              end else begin
                high = BAD_WORD;
                val  = BAD_WORD;
                bad  = 1'b1;
              end
            end
            push_head(high, n, bad);
            push_word(val, last, bad);
          end else begin
            push_word(w, last, 1'b0);
          end
          chan_pos = chan_pos + 6'd1;
        end
      end
      default: ;  // unused code: drop
    endcase
  endfunction

  // Scoreboard: check output beats, track register writes, predict from input beats
  always @(posedge clk) begin : score
    rec_word_t want;
    if (!rst_n) begin
      rec_id = '0; rec_crate = '0; rec_slot = '0; rec_mask = '0;
      rec_count = '0; rec_offset = '0; rec_clear = 1'b0;
      last_cnt = '0; wrap_cnt = '0; hdr_word = '0; chan_pos = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat: expected none, actual word %h last %b bad %b",
                   $realtime, out_tdata, out_tlast, out_tuser);
        end else begin
          want = pending_words.pop_front();
          if (out_tdata !== want.word) begin
            mismatches++;
            $display("%0t: word_out mismatch: expected %h, actual %h",
                     $realtime, want.word, out_tdata);
          end
          if (out_tlast !== want.last) begin
            mismatches++;
            $display("%0t: last_word mismatch: expected %b, actual %b",
                     $realtime, want.last, out_tlast);
          end
          if (out_tuser !== want.bad) begin
            mismatches++;
            $display("%0t: bad_count mismatch: expected %b, actual %b",
                     $realtime, want.bad, out_tuser);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_DATA_ID:        rec_id     = cfg_data;
          REG_CRATE_NUMBER:   rec_crate  = cfg_data[3:0];
          REG_SLOT_NUMBER:    rec_slot   = cfg_data[4:0];
          REG_ENABLED_MASK:   rec_mask   = cfg_data;
          REG_ENABLED_COUNT:  rec_count  = cfg_data[5:0];
          REG_COUNT_OFFSET:   rec_offset = cfg_data;
          REG_CLEAR_ON_START: rec_clear  = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) format_beat(in_tuser, in_tdata);
    end
  end

  // Receiver: stall on a repeating ready pattern that is redrawn periodically
  logic [7:0]  ready_pat = 8'hff;
  int unsigned ready_step = 0;

  always @(posedge clk) begin
    if (ready_step % 64 == 0)
      ready_pat = ($urandom_range(0, 3) == 0) ? 8'hff : (8'($urandom) | 8'h01);
    out_tready <= ready_pat[ready_step % 8];
    ready_step++;
  end

  task automatic send_beat(input logic [1:0] func, input logic [31:0] word);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, 6);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Hold the input until every expected word is out, then let the block settle
  task automatic wait_drained(input int extra);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] id, input logic [31:0] crate,
                              input logic [31:0] slot, input logic [31:0] mask,
                              input logic [31:0] count, input logic [31:0] offset,
                              input logic [31:0] clear);
    reg_idx_t    regs [7];
    logic [31:0] vals [7];
    regs = '{REG_DATA_ID, REG_CRATE_NUMBER, REG_SLOT_NUMBER, REG_ENABLED_MASK,
             REG_ENABLED_COUNT, REG_COUNT_OFFSET, REG_CLEAR_ON_START};
    vals = '{id, crate, slot, mask, count, offset, clear};
    wait_drained(8);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 7; i++) begin
      cfg_addr <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    gen_n = (count[5:0] > 6'(MAX_CH)) ? MAX_CH : int'(count[5:0]);
  endtask

  // Channel-0 counts: mostly rising, with drops and zeros mixed in
  function automatic logic [31:0] next_count();
    logic [31:0] w;
    int          r;
    r = $urandom_range(0, 9);
    if (r == 0)      w = '0;
    else if (r < 3)  w = $urandom;
    else             w = gen_last + 32'($urandom_range(1, 1000));
    if (w != 32'd0) gen_last = w;
    return w;
  endfunction

  function automatic logic [31:0] next_value();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_channels(input int cnt);
    for (int c = 0; c < cnt; c++)
      send_beat(FUNC_CHANNEL, (c == 0) ? next_count() : next_value());
  endtask

  task automatic run_phase(input int budget);
    int  sent;
    int  r;
    int  part;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    send_beat(FUNC_HEADER, $urandom);
    send_channels(gen_n);
    sent += gen_n + 1;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_beat(FUNC_START, $urandom);
        sent++;
      end else if (r < 80) begin
        send_beat(FUNC_HEADER, $urandom);
        send_channels(gen_n);
        sent += gen_n + 1;
        if ($urandom_range(0, 9) == 0) send_beat(FUNC_CHANNEL, $urandom);
      end else if (r < 90) begin
        // abandon a record part way through
        part = (gen_n > 1) ? $urandom_range(1, gen_n - 1) : 0;
        send_beat(FUNC_HEADER, $urandom);
        send_channels(part);
        sent += part + 1;
      end else begin
        r = $urandom_range(0, 3);
        send_beat(2'(r), $urandom);
        if (2'(r) != FUNC_UNUSED) sent++;
      end
      if (!paused && sent >= budget / 2) begin
        paused = 1'b1;
        wait_drained(0);
      end
    end
  endtask

  task automatic test_empty_records();
    // registers still at reset: no channels, every header is a full record
    send_beat(FUNC_HEADER, 32'h0000_0000);
    send_beat(FUNC_HEADER, 32'hffff_ffff);
    send_beat(FUNC_START, 32'h0);
    send_beat(FUNC_CHANNEL, 32'h1234_5678);
  endtask

  task automatic test_channel_zero_tracking();
    program_regs(32'h8000_0000, 32'd15, 32'd31, 32'hffff_ffff, 32'd2, 32'd0, 32'd1);
    send_beat(FUNC_START, 32'h0);
    send_beat(FUNC_HEADER, 32'hffff_ffff);
    send_beat(FUNC_CHANNEL, 32'd100);
    send_beat(FUNC_CHANNEL, 32'hffff_ffff);
    send_beat(FUNC_CHANNEL, 32'd5);          // beyond the record: dropped
    send_beat(FUNC_HEADER, 32'h0);
    send_beat(FUNC_CHANNEL, 32'd50);         // below the last count: wraps
    send_beat(FUNC_CHANNEL, 32'd0);
    send_beat(FUNC_HEADER, 32'ha5a5_5a5a);
    send_beat(FUNC_CHANNEL, 32'd0);          // zero count
    send_beat(FUNC_CHANNEL, 32'd1);
    send_beat(FUNC_HEADER, 32'd1);
    send_beat(FUNC_CHANNEL, 32'd60);
    send_beat(FUNC_HEADER, 32'd2);           // restarts the record
    send_beat(FUNC_CHANNEL, 32'd70);
    send_beat(FUNC_UNUSED, 32'hffff_ffff);
    send_beat(FUNC_CHANNEL, 32'd80);
    send_beat(FUNC_START, 32'h0);            // clears the tracking
    send_beat(FUNC_HEADER, 32'd3);
    send_beat(FUNC_CHANNEL, 32'd10);
    send_beat(FUNC_CHANNEL, 32'd11);
  endtask

  task automatic test_offset_and_clamp();
    // junk above the crate and slot fields must be dropped
    program_regs(32'h0, 32'hffff_fff0, 32'hffff_ffe0, 32'h1, 32'd40, 32'h8000_0000, 32'd0);
    send_beat(FUNC_HEADER, 32'h5555_aaaa);
    send_beat(FUNC_CHANNEL, 32'd5);
    send_beat(FUNC_CHANNEL, 32'd6);
    send_beat(FUNC_CHANNEL, 32'd7);
    program_regs(32'h0000_ffc0, 32'd0, 32'd0, 32'hffff_fffe, 32'd1, 32'hffff_ffff, 32'd0);
    send_beat(FUNC_HEADER, 32'h0);
    send_beat(FUNC_CHANNEL, 32'd0);          // extension off: passes unchanged
  endtask

  task automatic test_random_records();
    int budget;
    for (int p = 0; p < 7; p++) begin
      gaps_on = 1'b1;
      budget  = 64;
      case (p)
        0: program_regs($urandom, $urandom, $urandom, $urandom | 32'h1, 32'd1, 32'd0, 32'd1);
        1: begin
          program_regs(32'hffff_ffff, 32'd15, 32'd31, 32'hffff_ffff, 32'd32,
                       32'h7fff_ffff, 32'd0);
          gaps_on = 1'b0;
          budget  = 40;
        end
        2: program_regs($urandom, $urandom, $urandom, $urandom & ~32'h1, 32'd3,
                        $urandom, $urandom);
        3: begin
          program_regs($urandom, $urandom, $urandom, $urandom, 32'd0, $urandom, $urandom);
          budget = 40;
        end
        4: begin
          program_regs(32'h0, 32'h0, 32'h0, 32'h1, 32'd63, 32'h8000_0000, 32'd1);
          budget = 40;
        end
        5: begin
          program_regs($urandom, $urandom, $urandom, $urandom | 32'h1,
                       32'($urandom_range(2, 5)), $urandom, $urandom);
          gaps_on = 1'($urandom_range(0, 1));
        end
        default: program_regs($urandom, $urandom, $urandom, $urandom | 32'h1,
                              32'($urandom_range(1, 4)), -32'($urandom_range(1, 1000)),
                              $urandom);
      endcase
      run_phase(budget);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_records();
    test_channel_zero_tracking();
    test_offset_and_clamp();
    test_random_records();
    wait_drained(20);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
